[design/acc_pkg.sv]
package acc_pkg;

  typedef enum logic [2:0] {
    OP_MODE    = 3'd0,
    OP_MINUS   = 3'd1,
    OP_PLUS    = 3'd2,
    OP_TICK    = 3'd3,
    OP_REFRESH = 3'd4
  } op_e;

  typedef enum logic {
    CFG_LOCKOUT = 1'b0,
    CFG_BLINK   = 1'b1
  } cfg_idx_e;

  localparam logic [9:0]  LOCKOUT_RESET = 10'd300;
  localparam logic [15:0] BLINK_RESET   = 16'd1000;
  localparam logic [10:0] AGE_MAX       = 11'd2047;
  localparam logic [4:0]  HOURS_MAX     = 5'd23;
  localparam logic [5:0]  MINUTES_MAX   = 6'd59;
  localparam logic [4:0]  HOURS_RESET   = 5'd12;
  localparam logic [7:0]  SEG_BLANK     = 8'hFF;
  localparam logic [7:0]  SEG_DOT_MASK  = 8'h7F;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic [2:0] operation;
    logic [4:0] rtc_hours;
    logic [5:0] rtc_minutes;
  } in_word_t;

  typedef struct packed {
    logic [7:0] digit_hours_tens;
    logic [7:0] digit_hours_ones;
    logic [7:0] digit_minutes_tens;
    logic [7:0] digit_minutes_ones;
    logic       alarm_led_on;
    logic       alarm_ringing;
    logic       clock_write;
    logic [4:0] write_hours;
    logic [5:0] write_minutes;
  } out_word_t;

  typedef struct packed {
    logic armed;
    logic ringing;
    logic min_edit;
    logic hour_edit;
    logic clock_edit;
    logic alarm_edit;
    logic set;
  } mode_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } split_t;

  function automatic logic [4:0] hours_step(input logic [4:0] h, input logic up);
    logic [4:0] r;
    if (up) begin
      r = (h >= HOURS_MAX) ? 5'd0 : h + 5'd1;
    end else begin
      r = (h == 5'd0) ? HOURS_MAX : h - 5'd1;
    end
    return r;
  endfunction

  function automatic split_t dec_split(input logic [5:0] v);
    split_t s;
    s.tens = 3'd0;
    for (int i = 1; i <= 6; i++) begin
      if (v >= 6'(10 * i)) begin
        s.tens = 3'(i);
      end
    end
    s.ones = 4'(v - 6'({3'd0, s.tens}) * 6'd10);
    return s;
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [3:0] d, input logic show);
    logic [7:0] p;
    p = SEG_BLANK;
    if (show && d <= 4'd9) begin
      p = SEG_TABLE[d];
    end
    return p;
  endfunction

endpackage

[design/alarm_clock_controller.sv]
// Alarm clock controller. Each input word is one event (mode, minus/alarm or plus/toggle
// button, millisecond tick, or display refresh carrying the running clock time) and yields
// exactly one output word: four active-low seven-segment patterns, alarm status and a
// clock load request. Words pass through an input register and an output register, and one
// word can be taken every cycle while the output is not stalled; a stalled output holds the
// input register and stalls the input. The state update for a word happens as it moves into
// the output register. The configuration port is always ready and may be written only while
// no words are in flight.
module alarm_clock_controller import acc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic        s1_valid_q;
  in_word_t    s1_word_q;
  logic        out_valid_q;
  out_word_t   out_q, out_d;
  logic        advance;

  logic [9:0]  lockout_q;
  logic [15:0] blink_period_q;

  logic [4:0]  clock_hours_q, clock_hours_d;
  logic [5:0]  clock_minutes_q, clock_minutes_d;
  logic [4:0]  alarm_hours_q, alarm_hours_d;
  logic [5:0]  alarm_minutes_q, alarm_minutes_d;
  mode_t       mode_q, mode_d;
  logic        blink_phase_q, blink_phase_d;
  logic [15:0] blink_count_q, blink_count_d;
  logic [2:0]  locked_q, locked_d;
  logic [10:0] press_age_q, press_age_d;

  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_word_q <= in_word_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q      <= LOCKOUT_RESET;
      blink_period_q <= BLINK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LOCKOUT: lockout_q      <= cfg_data_i[9:0];
        CFG_BLINK:   blink_period_q <= cfg_data_i;
        default:     lockout_q      <= lockout_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hours_q   <= HOURS_RESET;
      clock_minutes_q <= '0;
      alarm_hours_q   <= '0;
      alarm_minutes_q <= '0;
      mode_q          <= '0;
      blink_phase_q   <= 1'b0;
      blink_count_q   <= '0;
      locked_q        <= '0;
      press_age_q     <= '0;
    end else if (advance) begin
      clock_hours_q   <= clock_hours_d;
      clock_minutes_q <= clock_minutes_d;
      alarm_hours_q   <= alarm_hours_d;
      alarm_minutes_q <= alarm_minutes_d;
      mode_q          <= mode_d;
      blink_phase_q   <= blink_phase_d;
      blink_count_q   <= blink_count_d;
      locked_q        <= locked_d;
      press_age_q     <= press_age_d;
    end
  end

  logic        wr;
  logic        up;
  logic        running;
  logic [4:0]  th, dh;
  logic [5:0]  tm, dm;
  logic [15:0] period;
  logic        show_h, show_m;
  split_t      sh, sm;

  always_comb begin
    clock_hours_d   = clock_hours_q;
    clock_minutes_d = clock_minutes_q;
    alarm_hours_d   = alarm_hours_q;
    alarm_minutes_d = alarm_minutes_q;
    mode_d          = mode_q;
    blink_phase_d   = blink_phase_q;
    blink_count_d   = blink_count_q;
    locked_d        = locked_q;
    press_age_d     = press_age_q;
    wr              = 1'b0;
    up              = (s1_word_q.operation == OP_PLUS);
    th              = mode_q.alarm_edit ? alarm_hours_q : clock_hours_q;
    tm              = mode_q.alarm_edit ? alarm_minutes_q : clock_minutes_q;
    period          = (blink_period_q == 16'd0) ? 16'd1 : blink_period_q;
    running         = mode_q.hour_edit || mode_q.min_edit || mode_q.ringing;

    if (s1_word_q.operation <= OP_PLUS) begin
      if (!locked_q[s1_word_q.operation[1:0]]) begin
        locked_d[s1_word_q.operation[1:0]] = 1'b1;
        press_age_d = '0;
        if (mode_q.hour_edit) begin
          if (s1_word_q.operation == OP_MODE) begin
            mode_d.hour_edit = 1'b0;
            mode_d.min_edit  = 1'b1;
          end else begin
            th = hours_step(th, up);
          end
        end else if (mode_q.min_edit) begin
          if (s1_word_q.operation == OP_MODE) begin
            mode_d.min_edit = 1'b0;
            if (mode_q.alarm_edit) begin
              mode_d.alarm_edit = 1'b0;
              mode_d.set        = 1'b1;
              mode_d.armed      = 1'b1;
            end else if (mode_q.clock_edit) begin
              mode_d.clock_edit = 1'b0;
              wr = 1'b1;
            end
          end else if (up) begin
            if (tm >= MINUTES_MAX) begin
              tm = '0;
              th = hours_step(th, 1'b1);
            end else begin
              tm = tm + 6'd1;
            end
          end else begin
            if (tm == 6'd0) begin
              tm = MINUTES_MAX;
              th = hours_step(th, 1'b0);
            end else begin
              tm = tm - 6'd1;
            end
          end
        end else begin
          if (s1_word_q.operation == OP_MODE) begin
            mode_d.hour_edit  = 1'b1;
            mode_d.clock_edit = 1'b1;
          end else if (s1_word_q.operation == OP_MINUS) begin
            mode_d.alarm_edit = 1'b1;
            mode_d.hour_edit  = 1'b1;
          end else begin
            if (mode_q.set) begin
              mode_d.armed = !mode_q.armed;
            end
            mode_d.ringing = 1'b0;
          end
        end
        if (mode_q.hour_edit || mode_q.min_edit) begin
          if (mode_q.alarm_edit) begin
            alarm_hours_d   = th;
            alarm_minutes_d = tm;
          end else begin
            clock_hours_d   = th;
            clock_minutes_d = tm;
          end
        end else if (s1_word_q.operation == OP_MINUS && !mode_q.set) begin
          alarm_hours_d   = clock_hours_q;
          alarm_minutes_d = clock_minutes_q;
        end
      end
    end else if (s1_word_q.operation == OP_TICK) begin
      if (press_age_q < AGE_MAX) begin
        press_age_d = press_age_q + 11'd1;
      end
      if (locked_q != 3'd0 && press_age_d > {1'b0, lockout_q}) begin
        locked_d = '0;
      end
      if (running) begin
        if ({1'b0, blink_count_q} + 17'd1 >= {1'b0, period}) begin
          blink_count_d = '0;
          blink_phase_d = !blink_phase_q;
        end else begin
          blink_count_d = blink_count_q + 16'd1;
        end
      end
    end else if (s1_word_q.operation == OP_REFRESH) begin
      if (!(mode_q.alarm_edit || mode_q.clock_edit)) begin
        clock_hours_d   = s1_word_q.rtc_hours;
        clock_minutes_d = s1_word_q.rtc_minutes;
      end
      if (mode_q.armed && !mode_q.ringing && clock_hours_d == alarm_hours_q &&
          clock_minutes_d == alarm_minutes_q) begin
        mode_d.ringing = 1'b1;
      end
    end

    if (!(mode_d.hour_edit || mode_d.min_edit || mode_d.ringing)) begin
      blink_count_d = '0;
      blink_phase_d = 1'b0;
    end

    dh     = mode_d.alarm_edit ? alarm_hours_d : clock_hours_d;
    dm     = mode_d.alarm_edit ? alarm_minutes_d : clock_minutes_d;
    show_h = (!mode_d.hour_edit && !mode_d.ringing) || blink_phase_d;
    show_m = (!mode_d.min_edit && !mode_d.ringing) || blink_phase_d;
    sh     = dec_split({1'b0, dh});
    sm     = dec_split(dm);

    out_d.digit_hours_tens   = seg_pattern({1'b0, sh.tens}, show_h);
    out_d.digit_hours_ones   = seg_pattern(sh.ones, show_h) & SEG_DOT_MASK;
    out_d.digit_minutes_tens = seg_pattern({1'b0, sm.tens}, show_m);
    out_d.digit_minutes_ones = seg_pattern(sm.ones, show_m);
    out_d.alarm_led_on       = mode_d.armed;
    out_d.alarm_ringing      = mode_d.ringing;
    out_d.clock_write        = wr;
    out_d.write_hours        = wr ? clock_hours_d : 5'd0;
    out_d.write_minutes      = wr ? clock_minutes_d : 6'd0;
  end

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_ring_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.alarm_ringing == mode_q.ringing &&
                     out_q.alarm_led_on == mode_q.armed))
    else $error("alarm status word disagrees with mode state");

  a_write_ends_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.clock_write) |-> (!mode_q.clock_edit && !mode_q.min_edit))
    else $error("clock load while still editing");

  a_blink_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mode_q.hour_edit || mode_q.min_edit || mode_q.ringing) |->
      (!blink_phase_q && blink_count_q == 16'd0))
    else $error("blink timer running while idle");

endmodule
